// ===== design/ile_pkg.sv =====
// shared codes, types and field widths of the indexed list engine
`default_nettype none

package ile_pkg;

  localparam int KIND_W   = 4;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;

  // operation kinds carried in tuser
  localparam logic [KIND_W-1:0] KIND_APPEND   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_INS_HEAD = 4'd1;
  localparam logic [KIND_W-1:0] KIND_INS_IDX  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_IDX  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_DEL_HEAD = 4'd4;
  localparam logic [KIND_W-1:0] KIND_DEL_TAIL = 4'd5;
  localparam logic [KIND_W-1:0] KIND_REP_IDX  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_REP_HEAD = 4'd7;
  localparam logic [KIND_W-1:0] KIND_REP_TAIL = 4'd8;
  localparam logic [KIND_W-1:0] KIND_GET_IDX  = 4'd9;
  localparam logic [KIND_W-1:0] KIND_GET_HEAD = 4'd10;
  localparam logic [KIND_W-1:0] KIND_GET_TAIL = 4'd11;
  localparam logic [KIND_W-1:0] KIND_REWIND   = 4'd12;
  localparam logic [KIND_W-1:0] KIND_NEXT     = 4'd13;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 4'd14;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INS,
    OP_DEL,
    OP_REP,
    OP_GET,
    OP_REWIND,
    OP_NEXT,
    OP_CLEAR
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_UP_LAST,
    S_DN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctrl_t;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic                found;
  } res_flags_t;

endpackage

`default_nettype wire

// ===== design/ile_store.sv =====
// element store: one write port, one registered read port
`default_nettype none

module ile_store #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire                    clk_i,
  input  wire ile_pkg::mem_ctrl_t ctrl_i,
  input  wire  [AW-1:0]          waddr_i,
  input  wire  [DATA_WIDTH-1:0]  wdata_i,
  input  wire  [AW-1:0]          raddr_i,
  output logic [DATA_WIDTH-1:0]  rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.re) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/ile_engine.sv =====
// operation decoder and element-move sequencer around the element store
`default_nettype none

module ile_engine #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32,
  localparam int CW    = $clog2(CAPACITY + 1),
  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CMP_W = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [ile_pkg::KIND_W-1:0]   kind_i,
  input  wire  [ile_pkg::POS_W-1:0]    position_i,
  input  wire  [DATA_WIDTH-1:0]        payload_i,
  input  wire                          res_ready_i,
  output ile_pkg::res_flags_t          res_o,
  output logic [CW-1:0]                res_ret_o,
  output logic [CW-1:0]                res_count_o,
  output logic [DATA_WIDTH-1:0]        res_word_o,
  output ile_pkg::mem_ctrl_t           mem_o,
  output logic [AW-1:0]                mem_waddr_o,
  output logic [DATA_WIDTH-1:0]        mem_wdata_o,
  output logic [AW-1:0]                mem_raddr_o,
  input  wire  [DATA_WIDTH-1:0]        mem_rdata_i
);

  ile_pkg::state_e state_q, state_d;

  logic [CW-1:0]                count_q, count_d;
  logic [CW-1:0]                cursor_q, cursor_d;
  logic [AW-1:0]                idx_q, idx_d;
  logic [AW-1:0]                tgt_q;
  logic [AW-1:0]                end_q;
  logic [DATA_WIDTH-1:0]        word_q;
  logic [ile_pkg::STATUS_W-1:0] status_q;
  logic [CW-1:0]                ret_q;
  logic                         found_q;

  // decode of the item at the input
  ile_pkg::op_e                 dec_op;
  logic [CMP_W-1:0]             n_ext;
  logic [CMP_W-1:0]             cur_ext;
  logic [CMP_W-1:0]             cap_ext;
  logic [CMP_W-1:0]             tgt;
  logic [CMP_W-1:0]             ret;
  logic                         is_append;
  logic [ile_pkg::STATUS_W-1:0] dec_status;
  logic                         dec_found;
  logic                         dec_ok;
  logic                         tgt_at_end;
  logic                         tgt_at_last;
  logic                         accept;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    n_ext     = CMP_W'(count_q);
    cur_ext   = CMP_W'(cursor_q);
    cap_ext   = CMP_W'(CAPACITY);
    dec_op    = ile_pkg::OP_NONE;
    tgt       = '0;
    is_append = 1'b0;
    case (kind_i)
      ile_pkg::KIND_APPEND: begin
        dec_op    = ile_pkg::OP_INS;
        tgt       = n_ext;
        is_append = 1'b1;
      end
      ile_pkg::KIND_INS_HEAD: dec_op = ile_pkg::OP_INS;
      ile_pkg::KIND_INS_IDX: begin
        dec_op = ile_pkg::OP_INS;
        tgt    = CMP_W'(position_i);
      end
      ile_pkg::KIND_DEL_IDX: begin
        dec_op = ile_pkg::OP_DEL;
        tgt    = CMP_W'(position_i);
      end
      ile_pkg::KIND_DEL_HEAD: dec_op = ile_pkg::OP_DEL;
      // on an empty list the tail index wraps to all ones and reads as out of range
      ile_pkg::KIND_DEL_TAIL: begin
        dec_op = ile_pkg::OP_DEL;
        tgt    = n_ext - CMP_W'(1);
      end
      ile_pkg::KIND_REP_IDX: begin
        dec_op = ile_pkg::OP_REP;
        tgt    = CMP_W'(position_i);
      end
      ile_pkg::KIND_REP_HEAD: dec_op = ile_pkg::OP_REP;
      ile_pkg::KIND_REP_TAIL: begin
        dec_op = ile_pkg::OP_REP;
        tgt    = n_ext - CMP_W'(1);
      end
      ile_pkg::KIND_GET_IDX: begin
        dec_op = ile_pkg::OP_GET;
        tgt    = CMP_W'(position_i);
      end
      ile_pkg::KIND_GET_HEAD: dec_op = ile_pkg::OP_GET;
      ile_pkg::KIND_GET_TAIL: begin
        dec_op = ile_pkg::OP_GET;
        tgt    = n_ext - CMP_W'(1);
      end
      ile_pkg::KIND_REWIND: dec_op = ile_pkg::OP_REWIND;
      ile_pkg::KIND_NEXT: begin
        dec_op = ile_pkg::OP_NEXT;
        tgt    = cur_ext;
      end
      ile_pkg::KIND_CLEAR: dec_op = ile_pkg::OP_CLEAR;
      default: dec_op = ile_pkg::OP_NONE;
    endcase

    tgt_at_end  = (tgt == n_ext);
    tgt_at_last = (tgt == n_ext - CMP_W'(1));
    dec_status  = ile_pkg::ST_OK;
    dec_found   = 1'b0;
    ret         = '0;
    count_d     = count_q;
    cursor_d    = cursor_q;
    case (dec_op)
      ile_pkg::OP_INS: begin
        if (tgt > n_ext) begin
          dec_status = ile_pkg::ST_RANGE;
        end else if (n_ext >= cap_ext) begin
          dec_status = ile_pkg::ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
          if (is_append || (tgt_at_end && tgt != '0)) begin
            ret = n_ext + CMP_W'(1);
          end else begin
            ret = tgt;
          end
        end
      end
      ile_pkg::OP_DEL: begin
        if (tgt >= n_ext) begin
          dec_status = ile_pkg::ST_RANGE;
        end else begin
          count_d = count_q - CW'(1);
          ret     = (tgt == '0 || tgt_at_last) ? n_ext - CMP_W'(1) : tgt;
        end
      end
      ile_pkg::OP_REP: begin
        if (tgt >= n_ext) begin
          dec_status = ile_pkg::ST_RANGE;
        end else begin
          ret = n_ext;
        end
      end
      ile_pkg::OP_GET: begin
        if (tgt >= n_ext) begin
          dec_status = ile_pkg::ST_RANGE;
        end else begin
          dec_found = 1'b1;
        end
      end
      ile_pkg::OP_NEXT: begin
        if (tgt >= n_ext) begin
          dec_status = ile_pkg::ST_RANGE;
        end else begin
          dec_found = 1'b1;
          cursor_d  = cursor_q + CW'(1);
        end
      end
      ile_pkg::OP_REWIND: cursor_d = '0;
      ile_pkg::OP_CLEAR: begin
        count_d  = '0;
        cursor_d = '0;
      end
      default: ;
    endcase
    dec_ok = (dec_status == ile_pkg::ST_OK);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ile_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = ile_pkg::S_DONE;
          if (dec_ok && dec_op == ile_pkg::OP_INS && !tgt_at_end) begin
            state_d = ile_pkg::S_UP;
          end
          if (dec_ok && dec_op == ile_pkg::OP_DEL && !tgt_at_last) begin
            state_d = ile_pkg::S_DN;
          end
        end
      end
      ile_pkg::S_UP: begin
        if (idx_q == tgt_q) begin
          state_d = ile_pkg::S_UP_LAST;
        end
      end
      ile_pkg::S_UP_LAST: state_d = ile_pkg::S_DONE;
      ile_pkg::S_DN: begin
        if (idx_q == end_q) begin
          state_d = ile_pkg::S_DONE;
        end
      end
      ile_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = ile_pkg::S_IDLE;
        end
      end
      default: state_d = ile_pkg::S_IDLE;
    endcase
  end

  // outputs: memory accesses, handshake and index stepping
  always_comb begin
    in_ready_o  = 1'b0;
    mem_o       = '0;
    mem_waddr_o = '0;
    mem_wdata_o = payload_i;
    mem_raddr_o = '0;
    idx_d       = idx_q;
    res_o       = '0;
    case (state_q)
      ile_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && dec_ok) begin
          case (dec_op)
            ile_pkg::OP_INS: begin
              if (tgt_at_end) begin
                mem_o.we    = 1'b1;
                mem_waddr_o = tgt[AW-1:0];
              end else begin
                // walk from the tail down, moving each element up one place
                mem_o.re    = 1'b1;
                mem_raddr_o = n_ext[AW-1:0] - AW'(1);
                idx_d       = n_ext[AW-1:0] - AW'(1);
              end
            end
            ile_pkg::OP_DEL: begin
              if (!tgt_at_last) begin
                mem_o.re    = 1'b1;
                mem_raddr_o = tgt[AW-1:0] + AW'(1);
                idx_d       = tgt[AW-1:0] + AW'(1);
              end
            end
            ile_pkg::OP_REP: begin
              mem_o.we    = 1'b1;
              mem_waddr_o = tgt[AW-1:0];
            end
            ile_pkg::OP_GET, ile_pkg::OP_NEXT: begin
              mem_o.re    = 1'b1;
              mem_raddr_o = tgt[AW-1:0];
            end
            default: ;
          endcase
        end
      end
      ile_pkg::S_UP: begin
        mem_o.we    = 1'b1;
        mem_waddr_o = idx_q + AW'(1);
        mem_wdata_o = mem_rdata_i;
        if (idx_q != tgt_q) begin
          mem_o.re    = 1'b1;
          mem_raddr_o = idx_q - AW'(1);
          idx_d       = idx_q - AW'(1);
        end
      end
      ile_pkg::S_UP_LAST: begin
        mem_o.we    = 1'b1;
        mem_waddr_o = tgt_q;
        mem_wdata_o = word_q;
      end
      ile_pkg::S_DN: begin
        mem_o.we    = 1'b1;
        mem_waddr_o = idx_q - AW'(1);
        mem_wdata_o = mem_rdata_i;
        if (idx_q != end_q) begin
          mem_o.re    = 1'b1;
          mem_raddr_o = idx_q + AW'(1);
          idx_d       = idx_q + AW'(1);
        end
      end
      ile_pkg::S_DONE: begin
        res_o.valid  = 1'b1;
        res_o.status = status_q;
        res_o.found  = found_q;
      end
      default: ;
    endcase
  end

  // read data stays in the store's output register while no read is issued
  assign res_word_o  = found_q ? mem_rdata_i : '0;
  assign res_ret_o   = ret_q;
  assign res_count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ile_pkg::S_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        count_q  <= count_d;
        cursor_q <= cursor_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (accept) begin
      tgt_q    <= tgt[AW-1:0];
      end_q    <= n_ext[AW-1:0] - AW'(1);
      word_q   <= payload_i;
      status_q <= dec_status;
      ret_q    <= ret[CW-1:0];
      found_q  <= dec_found;
    end
  end

endmodule

`default_nettype wire

// ===== design/indexed_list_engine.sv =====
// top level of the indexed list engine: stream ports, result register, engine and store
//
//   channel  | direction | tdata (low bit up)                         | tuser
//   s_*      | in        | position, payload                          | kind
//   m_*      | out       | status, ret_value, read_word, read_found,  | -
//            |           | list_count                                 |
//
// items are accepted only while the engine is idle, after the previous result is registered;
// insert at index k below the tail and delete at index k (not the tail) shift the elements
// in between one place, since the single-write store moves one element per cycle.
// reset clears the count, the cursor and the control state; stored words are not cleared.
// a stalled result sits in the output register while the next item is accepted and worked;
// that item waits in its final state until the register frees up.
`default_nettype none

module indexed_list_engine #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32,
  localparam int CW       = $clog2(CAPACITY + 1),
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int IN_BITS  = ile_pkg::POS_W + DATA_WIDTH,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = ile_pkg::STATUS_W + CW + DATA_WIDTH + 1 + CW,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        s_tvalid,
  output logic                       s_tready,
  input  wire  [IN_W-1:0]            s_tdata,   // position, payload
  input  wire  [ile_pkg::KIND_W-1:0] s_tuser,   // kind
  output logic                       m_tvalid,
  input  wire                        m_tready,
  output logic [OUT_W-1:0]           m_tdata    // status, ret_value, read_word, read_found,
                                                // list_count
);

  ile_pkg::res_flags_t res;
  logic [CW-1:0]         res_ret;
  logic [CW-1:0]         res_count;
  logic [DATA_WIDTH-1:0] res_word;
  logic                  res_ready;

  ile_pkg::mem_ctrl_t    mem_ctrl;
  logic [AW-1:0]         mem_waddr;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic                         m_valid_q;
  logic [ile_pkg::STATUS_W-1:0] status_q;
  logic [CW-1:0]                ret_value_q;
  logic [DATA_WIDTH-1:0]        read_word_q;
  logic                         read_found_q;
  logic [CW-1:0]                list_count_q;

  ile_engine #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .kind_i      (s_tuser),
    .position_i  (s_tdata[ile_pkg::POS_W-1:0]),
    .payload_i   (s_tdata[ile_pkg::POS_W +: DATA_WIDTH]),
    .res_ready_i (res_ready),
    .res_o       (res),
    .res_ret_o   (res_ret),
    .res_count_o (res_count),
    .res_word_o  (res_word),
    .mem_o       (mem_ctrl),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ile_store #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .ctrl_i  (mem_ctrl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !m_valid_q || m_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      status_q     <= res.status;
      ret_value_q  <= res_ret;
      read_word_q  <= res_word;
      read_found_q <= res.found;
      list_count_q <= res_count;
    end
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = OUT_W'({list_count_q, read_found_q, read_word_q, ret_value_q, status_q});

endmodule

`default_nettype wire

// ===== design/ile_checker.sv =====
// port-level checks on the indexed list engine, bound to the top level
`default_nettype none

module ile_checker #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32,
  localparam int CW       = $clog2(CAPACITY + 1),
  localparam int OUT_BITS = ile_pkg::STATUS_W + CW + DATA_WIDTH + 1 + CW,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input wire             clk_i,
  input wire             rst_ni,
  input wire             s_tvalid_i,
  input wire             s_tready_i,
  input wire             m_tvalid_i,
  input wire             m_tready_i,
  input wire [OUT_W-1:0] m_tdata_i
);

  logic [ile_pkg::STATUS_W-1:0] status;
  logic [CW-1:0]                ret_value;
  logic [DATA_WIDTH-1:0]        read_word;
  logic                         read_found;
  logic [CW-1:0]                list_count;

  assign status     = m_tdata_i[ile_pkg::STATUS_W-1:0];
  assign ret_value  = m_tdata_i[ile_pkg::STATUS_W +: CW];
  assign read_word  = m_tdata_i[ile_pkg::STATUS_W + CW +: DATA_WIDTH];
  assign read_found = m_tdata_i[ile_pkg::STATUS_W + CW + DATA_WIDTH];
  assign list_count = m_tdata_i[ile_pkg::STATUS_W + CW + DATA_WIDTH + 1 +: CW];

  // a stalled result transaction holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result changed while stalled");

  // input ready is low right after every accepted item, since the engine leaves idle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("input ready right after an accepted item");

  // a failed operation returns nothing
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && status != ile_pkg::ST_OK |->
      ret_value == '0 && read_word == '0 && !read_found)
    else $error("error result carries data");

  // length stays in range and status is a known code
  a_count_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> list_count <= CW'(CAPACITY) &&
      (status == ile_pkg::ST_OK || status == ile_pkg::ST_RANGE ||
       status == ile_pkg::ST_FULL))
    else $error("bad length or status");

endmodule

bind indexed_list_engine ile_checker #(
  .CAPACITY   (CAPACITY),
  .DATA_WIDTH (DATA_WIDTH)
) u_ile_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid),
  .s_tready_i (s_tready),
  .m_tvalid_i (m_tvalid),
  .m_tready_i (m_tready),
  .m_tdata_i  (m_tdata)
);

`default_nettype wire

// ===== dv/tb_indexed_list_engine.sv =====
`timescale 1ns / 1ps
// testbench of the indexed list engine: directed and random list operations, per-result checks
module tb_indexed_list_engine;

  localparam int CAPACITY     = 64;
  localparam int DATA_WIDTH   = 32;
  localparam int CW           = 7;
  localparam int IN_W         = 40;
  localparam int OUT_W        = 56;
  localparam int RES_BITS     = 49;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 100;

  // kind 15 has no operation behind it
  localparam logic [ile_pkg::KIND_W-1:0] KIND_UNUSED = 4'd15;

  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN
  } mix_e;

  // packed from the msb down, so it lines up with m_tdata[RES_BITS-1:0]
  typedef struct packed {
    logic [CW-1:0]                list_count;
    logic                         read_found;
    logic [DATA_WIDTH-1:0]        read_word;
    logic [CW-1:0]                ret_value;
    logic [ile_pkg::STATUS_W-1:0] status;
  } list_result_t;

  logic                       clk_i    = 1'b0;
  logic                       rst_ni   = 1'b0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [IN_W-1:0]            s_tdata  = '0;   // position, payload
  logic [ile_pkg::KIND_W-1:0] s_tuser  = '0;   // kind
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [OUT_W-1:0]           m_tdata;  // status, ret_value, read_word, read_found, list_count

  // shadow copy of the list
  logic [DATA_WIDTH-1:0] shadow_words [CAPACITY];
  int                    shadow_len  = 0;
  int                    shadow_walk = 0;

  list_result_t pending_results[$];
  int           fail_count  = 0;
  int           cycle_count = 0;
  int           sink_stall  = 0;
  bit           quiet       = 1'b0;

  indexed_list_engine #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // applies one operation to the shadow list and returns the result it should give
  function automatic list_result_t apply_list_op(input logic [ile_pkg::KIND_W-1:0] kind,
                                                 input logic [ile_pkg::POS_W-1:0] pos,
                                                 input logic [DATA_WIDTH-1:0] word);
    list_result_t  r;
    ile_pkg::op_e  op;
    int            at;
    int            n;
    int            i;
    bit            is_append;
    r         = '0;
    n         = shadow_len;
    at        = int'(pos);
    is_append = 1'b0;
    case (kind)
      ile_pkg::KIND_APPEND: begin
        op = ile_pkg::OP_INS; at = n; is_append = 1'b1;
      end
      ile_pkg::KIND_INS_HEAD: begin op = ile_pkg::OP_INS; at = 0; end
      ile_pkg::KIND_INS_IDX:  op = ile_pkg::OP_INS;
      ile_pkg::KIND_DEL_IDX:  op = ile_pkg::OP_DEL;
      ile_pkg::KIND_DEL_HEAD: begin op = ile_pkg::OP_DEL; at = 0; end
      ile_pkg::KIND_DEL_TAIL: begin op = ile_pkg::OP_DEL; at = n - 1; end
      ile_pkg::KIND_REP_IDX:  op = ile_pkg::OP_REP;
      ile_pkg::KIND_REP_HEAD: begin op = ile_pkg::OP_REP; at = 0; end
      ile_pkg::KIND_REP_TAIL: begin op = ile_pkg::OP_REP; at = n - 1; end
      ile_pkg::KIND_GET_IDX:  op = ile_pkg::OP_GET;
      ile_pkg::KIND_GET_HEAD: begin op = ile_pkg::OP_GET; at = 0; end
      ile_pkg::KIND_GET_TAIL: begin op = ile_pkg::OP_GET; at = n - 1; end
      ile_pkg::KIND_REWIND:   op = ile_pkg::OP_REWIND;
      ile_pkg::KIND_NEXT:     op = ile_pkg::OP_NEXT;
      ile_pkg::KIND_CLEAR:    op = ile_pkg::OP_CLEAR;
      default:                op = ile_pkg::OP_NONE;
    endcase
    case (op)
      ile_pkg::OP_INS: begin
        // range is checked ahead of the full check
        if (at > n) r.status = ile_pkg::ST_RANGE;
        else if (n >= CAPACITY) r.status = ile_pkg::ST_FULL;
        else begin
          for (i = n; i > at; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[at] = word;
          shadow_len = n + 1;
          if (is_append || (at == n && at != 0)) r.ret_value = CW'(shadow_len);
          else r.ret_value = CW'(at);
        end
      end
      ile_pkg::OP_DEL: begin
        if (at < 0 || at >= n) r.status = ile_pkg::ST_RANGE;
        else begin
          for (i = at; i + 1 < n; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len = n - 1;
          r.ret_value = (at == 0 || at == shadow_len) ? CW'(shadow_len) : CW'(at);
        end
      end
      ile_pkg::OP_REP: begin
        if (at < 0 || at >= n) r.status = ile_pkg::ST_RANGE;
        else begin
          shadow_words[at] = word;
          r.ret_value = CW'(n);
        end
      end
      ile_pkg::OP_GET: begin
        if (at < 0 || at >= n) r.status = ile_pkg::ST_RANGE;
        else begin
          r.read_word  = shadow_words[at];
          r.read_found = 1'b1;
        end
      end
      ile_pkg::OP_REWIND: shadow_walk = 0;
      ile_pkg::OP_NEXT: begin
        // the cursor is a plain position and may sit past the end after deletes
        if (shadow_walk >= n) r.status = ile_pkg::ST_RANGE;
        else begin
          r.read_word  = shadow_words[shadow_walk];
          r.read_found = 1'b1;
          shadow_walk++;
        end
      end
      ile_pkg::OP_CLEAR: begin
        shadow_len  = 0;
        shadow_walk = 0;
      end
      default: ;
    endcase
    r.list_count = CW'(shadow_len);
    return r;
  endfunction

  task automatic send_op(input logic [ile_pkg::KIND_W-1:0] kind,
                         input logic [ile_pkg::POS_W-1:0] pos,
                         input logic [DATA_WIDTH-1:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {word, pos};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    pending_results.push_back(apply_list_op(kind, pos, word));
  endtask

  // result side: random backpressure and the compare against the oldest prediction
  always @(posedge clk_i) begin : result_check
    list_result_t got;
    list_result_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[RES_BITS-1:0];
        if (pending_results.size() == 0) begin
          $display("%0t: result with no transaction pending: %h", $time, got);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch exp status=%0d ret=%0d word=%h found=%0d count=%0d",
                     $time, want.status, want.ret_value, want.read_word, want.read_found,
                     want.list_count);
            $display("%0t:          got status=%0d ret=%0d word=%h found=%0d count=%0d",
                     $time, got.status, got.ret_value, got.read_word, got.read_found,
                     got.list_count);
            fail_count++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else begin
        sink_stall = pick_gap();
        if (sink_stall > 0) begin
          sink_stall--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  task automatic test_empty_list();
    send_op(ile_pkg::KIND_DEL_IDX, 8'd0, 32'h0);
    send_op(ile_pkg::KIND_DEL_HEAD, 8'd0, 32'h0);
    send_op(ile_pkg::KIND_DEL_TAIL, 8'd0, 32'h0);
    send_op(ile_pkg::KIND_REP_IDX, 8'd0, 32'h1234_5678);
    send_op(ile_pkg::KIND_REP_HEAD, 8'd0, 32'h1234_5678);
    send_op(ile_pkg::KIND_REP_TAIL, 8'd0, 32'h1234_5678);
    send_op(ile_pkg::KIND_GET_IDX, 8'd0, 32'h0);
    send_op(ile_pkg::KIND_GET_HEAD, 8'd0, 32'h0);
    send_op(ile_pkg::KIND_GET_TAIL, 8'd0, 32'h0);
    // walk on an empty list ends at once
    send_op(ile_pkg::KIND_NEXT, 8'd0, 32'h0);
    send_op(ile_pkg::KIND_INS_IDX, 8'd1, 32'hdead_beef);
  endtask

  task automatic test_index_edges();
    send_op(ile_pkg::KIND_APPEND, 8'd0, 32'h0000_0000);
    send_op(ile_pkg::KIND_INS_HEAD, 8'd0, 32'hffff_ffff);
    send_op(ile_pkg::KIND_INS_IDX, 8'd2, 32'ha5a5_5a5a);
    send_op(ile_pkg::KIND_INS_IDX, 8'd1, 32'h0f0f_f0f0);
    send_op(ile_pkg::KIND_REP_TAIL, 8'd0, 32'h8000_0001);
    send_op(ile_pkg::KIND_GET_IDX, 8'd255, 32'h0);
    send_op(ile_pkg::KIND_DEL_IDX, 8'd3, 32'h0);
    send_op(ile_pkg::KIND_GET_TAIL, 8'd0, 32'h0);
  endtask

  task automatic test_cursor_walk();
    send_op(ile_pkg::KIND_REWIND, 8'd0, 32'h0);
    send_op(ile_pkg::KIND_NEXT, 8'd0, 32'h0);
    // cursor stays put while elements shift under it
    send_op(ile_pkg::KIND_DEL_HEAD, 8'd0, 32'h0);
    send_op(ile_pkg::KIND_NEXT, 8'd0, 32'h0);
    send_op(ile_pkg::KIND_NEXT, 8'd0, 32'h0);
  endtask

  task automatic test_clear_unused();
    send_op(KIND_UNUSED, 8'd255, 32'hffff_ffff);
    send_op(ile_pkg::KIND_CLEAR, 8'd0, 32'h0);
    send_op(ile_pkg::KIND_NEXT, 8'd0, 32'h0);
  endtask

  task automatic random_op(input mix_e mix);
    int                         r;
    int                         n;
    int                         top;
    int                         ins_w;
    int                         del_w;
    logic [ile_pkg::KIND_W-1:0] kind;
    logic [ile_pkg::POS_W-1:0]  pos;
    logic [DATA_WIDTH-1:0]      word;
    n     = shadow_len;
    ins_w = (mix == MIX_GROW) ? 55 : (mix == MIX_SHRINK) ? 12 : 30;
    del_w = (mix == MIX_GROW) ? 10 : (mix == MIX_SHRINK) ? 55 : 30;
    r     = $urandom_range(0, 99);
    if (r < ins_w) begin
      case ($urandom_range(0, 2))
        0:       kind = ile_pkg::KIND_APPEND;
        1:       kind = ile_pkg::KIND_INS_HEAD;
        default: kind = ile_pkg::KIND_INS_IDX;
      endcase
    end else if (r < ins_w + del_w) begin
      case ($urandom_range(0, 2))
        0:       kind = ile_pkg::KIND_DEL_IDX;
        1:       kind = ile_pkg::KIND_DEL_HEAD;
        default: kind = ile_pkg::KIND_DEL_TAIL;
      endcase
    end else if (mix == MIX_EVEN && r >= 98) begin
      kind = (r == 99) ? KIND_UNUSED : ile_pkg::KIND_CLEAR;
    end else begin
      case ($urandom_range(0, 8))
        0:       kind = ile_pkg::KIND_REP_IDX;
        1:       kind = ile_pkg::KIND_REP_HEAD;
        2:       kind = ile_pkg::KIND_REP_TAIL;
        3:       kind = ile_pkg::KIND_GET_IDX;
        4:       kind = ile_pkg::KIND_GET_HEAD;
        5:       kind = ile_pkg::KIND_GET_TAIL;
        6:       kind = ile_pkg::KIND_REWIND;
        default: kind = ile_pkg::KIND_NEXT;
      endcase
    end
    // mostly legal positions, some just past the end, some anywhere
    top = (kind == ile_pkg::KIND_INS_IDX) ? n : n - 1;
    r   = $urandom_range(0, 99);
    if (r < 80 && top >= 0) pos = ile_pkg::POS_W'($urandom_range(0, top));
    else if (r < 90) pos = ile_pkg::POS_W'(top + 1);
    else pos = ile_pkg::POS_W'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 5) word = '0;
    else if (r < 10) word = '1;
    else word = $urandom;
    send_op(kind, pos, word);
  endtask

  task automatic test_random_mix();
    int round;
    for (round = 0; round < 3; round++) begin
      quiet = (round == 1);
      repeat (130) random_op(MIX_GROW);
      quiet = 1'b0;
      repeat (100) random_op(MIX_SHRINK);
      quiet = (round == 2);
      repeat (40) random_op(MIX_EVEN);
      quiet = 1'b0;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_index_edges();
    test_cursor_walk();
    test_clear_unused();
    test_random_mix();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
